/* rtl/crs_pkg.sv */
package crs_pkg;

	localparam int WINDOW_BYTES = 8;
	localparam int BYTE_W       = 8;
	localparam int WORD_W       = WINDOW_BYTES * BYTE_W;
	localparam int COUNT_W      = 32;
	localparam int DISP_W       = 32;
	localparam int CFG_IDX_W    = 2;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 2'd1;

	// Instruction pattern of a RIP-relative lea or mov.
	localparam logic [7:0] REX_MASK   = 8'hF0;
	localparam logic [7:0] REX_VALUE  = 8'h40;
	localparam logic [7:0] OP_LEA     = 8'h8D;
	localparam logic [7:0] OP_MOV     = 8'h8B;
	localparam logic [7:0] MODRM_MASK = 8'hC7;
	localparam logic [7:0] MODRM_RIP  = 8'h05;

	localparam logic [COUNT_W-1:0] WINDOW_COUNT = COUNT_W'(WINDOW_BYTES);

	// Contents of the input stage: the window as it stood when the byte arrived.
	typedef struct packed {
		logic                judge;
		logic [WORD_W-1:0]   window_word;
		logic [COUNT_W-1:0]  pos;
		logic [WORD_W-1:0]   rip_off;
		logic                last;
	} stage1_t;

	typedef struct packed {
		logic              hit;
		logic              hit_kind;
		logic [WORD_W-1:0] hit_address;
		logic              scan_done;
	} result_t;

endpackage

/* rtl/crs_if.sv */
interface crs_code_if;
	logic       valid;
	logic       ready;
	logic [7:0] code_byte;
	logic       last_byte;

	modport source (output valid, output code_byte, output last_byte, input ready);
	modport sink (input valid, input code_byte, input last_byte, output ready);
endinterface

interface crs_result_if;
	logic        valid;
	logic        ready;
	logic        hit;
	logic        hit_kind;
	logic [63:0] hit_address;
	logic        scan_done;

	modport source (output valid, output hit, output hit_kind, output hit_address,
		output scan_done, input ready);
	modport sink (input valid, input hit, input hit_kind, input hit_address,
		input scan_done, output ready);
endinterface

interface crs_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [63:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/crs_front.sv */
module crs_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [7:0]                    code_byte,
	input  logic                          last_byte,
	output crs_pkg::stage1_t              stage_s1
);

	logic [crs_pkg::BYTE_W-1:0]  win_q [crs_pkg::WINDOW_BYTES];
	logic [crs_pkg::COUNT_W-1:0] count_q;
	logic [crs_pkg::WORD_W-1:0]  word;
	logic [crs_pkg::DISP_W-1:0]  disp;
	crs_pkg::stage1_t            next_s1;

	always_comb begin
		for (int i = 0; i < crs_pkg::WINDOW_BYTES; i++) begin
			word[crs_pkg::BYTE_W*i +: crs_pkg::BYTE_W] = win_q[i];
		end
	end

	// Displacement sits in bytes three to six of the judged position.
	assign disp = word[3*crs_pkg::BYTE_W +: crs_pkg::DISP_W];

	// Position plus seven is the count less one, since the position is the count less eight.
	always_comb begin
		next_s1.judge       = (count_q >= crs_pkg::WINDOW_COUNT);
		next_s1.window_word = word;
		next_s1.pos         = count_q - crs_pkg::WINDOW_COUNT;
		next_s1.rip_off     = crs_pkg::WORD_W'(count_q) - crs_pkg::WORD_W'(1)
			+ {{(crs_pkg::WORD_W-crs_pkg::DISP_W){disp[crs_pkg::DISP_W-1]}}, disp};
		next_s1.last        = last_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < crs_pkg::WINDOW_BYTES; i++) begin
				win_q[i] <= '0;
			end
			count_q <= '0;
		end else if (accept) begin
			for (int i = 0; i < crs_pkg::WINDOW_BYTES - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[crs_pkg::WINDOW_BYTES-1] <= code_byte;
			count_q <= last_byte ? '0 : count_q + crs_pkg::COUNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stage_s1 <= next_s1;
		end
	end

endmodule

/* rtl/crs_judge.sv */
module crs_judge (
	input  crs_pkg::stage1_t                stage_s1,
	input  logic [crs_pkg::WORD_W-1:0]      target_address,
	input  logic [crs_pkg::WORD_W-1:0]      base_address,
	output crs_pkg::result_t                result
);

	logic [crs_pkg::WORD_W-1:0] addr;
	logic [crs_pkg::WORD_W-1:0] rip_addr;
	logic [crs_pkg::BYTE_W-1:0] b0, b1, b2;
	logic                       abs_match;
	logic                       opc_match;
	logic                       rip_match;

	assign b0 = stage_s1.window_word[0 +: crs_pkg::BYTE_W];
	assign b1 = stage_s1.window_word[crs_pkg::BYTE_W +: crs_pkg::BYTE_W];
	assign b2 = stage_s1.window_word[2*crs_pkg::BYTE_W +: crs_pkg::BYTE_W];

	// The two sums run side by side; only the RIP-relative one is compared with the target.
	assign addr      = base_address + crs_pkg::WORD_W'(stage_s1.pos);
	assign rip_addr  = base_address + stage_s1.rip_off;
	assign abs_match = (stage_s1.window_word == target_address);
	assign opc_match = ((b0 & crs_pkg::REX_MASK) == crs_pkg::REX_VALUE)
		&& ((b1 == crs_pkg::OP_LEA) || (b1 == crs_pkg::OP_MOV))
		&& ((b2 & crs_pkg::MODRM_MASK) == crs_pkg::MODRM_RIP);
	assign rip_match = (rip_addr == target_address);

	always_comb begin
		result.hit         = stage_s1.judge && (abs_match || (opc_match && rip_match));
		result.hit_kind    = stage_s1.judge && !abs_match && opc_match && rip_match;
		result.hit_address = stage_s1.judge ? addr : '0;
		result.scan_done   = stage_s1.last;
	end

endmodule

/* rtl/code_reference_scanner_unit.sv */
// Code reference scanner.
// The code channel takes one machine-code byte per request, with last_byte set on
// the final byte of a region. The block holds the last eight bytes and, for every
// byte, returns one request on the result channel judging the position eight bytes
// back: an absolute 64-bit pointer to the target (kind 0) or a RIP-relative lea/mov
// whose effective address is the target (kind 1). The first eight results of a
// region judge nothing and carry zero in hit, hit_kind and hit_address.
// The cfg channel writes target_address (index 0) and base_address (index 1); it is
// always ready and must only be used while the scanner is empty. Other indexes are
// ignored.
// An accepted byte is registered in the input stage, judged there, and moves on into
// the result register once that register is free; its result is offered from there.
// One byte per cycle is sustained while the receiver keeps ready high. The input
// stage and the result register each hold one request, so a stalled receiver leaves
// at most two requests waiting inside the block, and code.ready falls as soon as
// both are full.
// Reset clears the window, the byte count, the target and base registers and all valid flags.
module code_reference_scanner_unit (
	input  logic                clk,
	input  logic                arst_n,
	crs_code_if.sink            code,
	crs_result_if.source        result,
	crs_cfg_if.sink             cfg
);

	logic [crs_pkg::WORD_W-1:0] target_q;
	logic [crs_pkg::WORD_W-1:0] base_q;
	logic                       valid_s1;
	logic                       out_valid_q;
	logic                       out_free;
	logic                       s1_move;
	logic                       accept;
	crs_pkg::stage1_t           stage_s1;
	crs_pkg::result_t           judged;
	crs_pkg::result_t           out_q;

	// The result register frees when empty or being taken; the input stage moves on
	// into it whenever it is free, so a byte may enter each cycle while it stays free.
	assign out_free   = !out_valid_q || result.ready;
	assign s1_move    = valid_s1 && out_free;
	assign code.ready = !valid_s1 || out_free;
	assign accept     = code.valid && code.ready;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			base_q   <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				crs_pkg::CFG_TARGET: target_q <= cfg.data;
				crs_pkg::CFG_BASE:   base_q   <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	crs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.code_byte (code.code_byte),
		.last_byte (code.last_byte),
		.stage_s1  (stage_s1)
	);

	crs_judge u_judge (
		.stage_s1       (stage_s1),
		.target_address (target_q),
		.base_address   (base_q),
		.result         (judged)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end
			if (s1_move) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_q <= judged;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.hit         = out_q.hit;
	assign result.hit_kind    = out_q.hit_kind;
	assign result.hit_address = out_q.hit_address;
	assign result.scan_done   = out_q.scan_done;

endmodule

/* tb/crs_scan_checker.sv */
module crs_scan_checker (
	input  logic  clk,
	input  logic  arst_n,
	crs_code_if   code,
	crs_result_if result,
	crs_cfg_if    cfg,
	output int    mismatch_count,
	output int    verdicts_due
);
	timeunit 1ns;
	timeprecision 1ps;
	import crs_pkg::*;

	logic [BYTE_W-1:0]  window [WINDOW_BYTES];
	logic [COUNT_W-1:0] seen;
	logic [WORD_W-1:0]  target;
	logic [WORD_W-1:0]  base;
	result_t            expected_verdicts [$];
	result_t            got;
	result_t            want;
	int                 results_seen;
	int                 i;

	// Judges the oldest position held in the window, as the block does when a byte arrives.
	function automatic result_t judge_oldest(input logic last);
		logic [WORD_W-1:0] word;
		logic [WORD_W-1:0] disp;
		result_t           v;
		int                k;
		v = '0;
		v.scan_done = last;
		if (seen >= WINDOW_COUNT) begin
			v.hit_address = base + WORD_W'(seen - WINDOW_COUNT);
			for (k = 0; k < WINDOW_BYTES; k++)
				word[BYTE_W*k +: BYTE_W] = window[k];
			if (word == target) begin
				v.hit = 1'b1;
			end else if ((window[0] & REX_MASK) == REX_VALUE &&
					(window[1] == OP_LEA || window[1] == OP_MOV) &&
					(window[2] & MODRM_MASK) == MODRM_RIP) begin
				disp = {{(WORD_W-DISP_W){window[6][7]}}, window[6], window[5], window[4],
					window[3]};
				if (v.hit_address + WORD_W'(7) + disp == target) begin
					v.hit      = 1'b1;
					v.hit_kind = 1'b1;
				end
			end
		end
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (i = 0; i < WINDOW_BYTES; i++)
				window[i] = '0;
			seen   = '0;
			target = '0;
			base   = '0;
			expected_verdicts.delete();
			results_seen   = 0;
			mismatch_count = 0;
			verdicts_due   = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_TARGET: target = cfg.data;
					CFG_BASE:   base = cfg.data;
					default: ;
				endcase
			end
			if (code.valid && code.ready) begin
				expected_verdicts.insert(expected_verdicts.size(),
					judge_oldest(code.last_byte));
				for (i = 0; i < WINDOW_BYTES - 1; i++)
					window[i] = window[i+1];
				window[WINDOW_BYTES-1] = code.code_byte;
				seen = code.last_byte ? '0 : seen + 1'b1;
			end
			if (result.valid && result.ready) begin
				got.hit         = result.hit;
				got.hit_kind    = result.hit_kind;
				got.hit_address = result.hit_address;
				got.scan_done   = result.scan_done;
				if (expected_verdicts.size() == 0) begin
					$display("%0t result %0d: expected none, got %b/%b/%h/%b", $time,
						results_seen, got.hit, got.hit_kind, got.hit_address, got.scan_done);
					mismatch_count++;
				end else begin
					want = expected_verdicts.pop_front();
					if (got.hit !== want.hit || got.hit_kind !== want.hit_kind ||
							got.hit_address !== want.hit_address ||
							got.scan_done !== want.scan_done) begin
						$display("%0t result %0d: expected %b/%b/%h/%b, got %b/%b/%h/%b",
							$time, results_seen, want.hit, want.hit_kind, want.hit_address,
							want.scan_done, got.hit, got.hit_kind, got.hit_address,
							got.scan_done);
						mismatch_count++;
					end
				end
				results_seen++;
			end
			verdicts_due = expected_verdicts.size();
		end
	end

endmodule

/* tb/tb_code_reference_scanner_unit.sv */
module tb_code_reference_scanner_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import crs_pkg::*;

	// Register indexes past the end of the list; the block must ignore writes to them.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
	localparam int                   PHASES       = 8;
	localparam int                   PHASE_BYTES  = 225;
	localparam logic [WORD_W-1:0]    ALL_ONES     = '1;

	typedef enum int {STALL_NONE, STALL_CADENCE, STALL_COIN, STALL_LONG} stall_mode_t;

	logic              clk = 1'b0;
	logic              arst_n;
	int                mismatch_count;
	int                verdicts_due;
	// The settings currently programmed, kept here only to build meaningful code bytes.
	logic [WORD_W-1:0] target_now;
	logic [WORD_W-1:0] base_now;
	// Bytes of the region being assembled, sent in one go with last_byte on the final one.
	logic [BYTE_W-1:0] region_bytes [$];
	int                burst_left = 0;
	int                phase;
	int                sent;
	int                offset;

	crs_code_if   code_bus ();
	crs_result_if result_bus ();
	crs_cfg_if    cfg_bus ();

	code_reference_scanner_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.code   (code_bus),
		.result (result_bus),
		.cfg    (cfg_bus)
	);

	// The checker watches all three channels, predicts every result and counts failures.
	crs_scan_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.code           (code_bus),
		.result         (result_bus),
		.cfg            (cfg_bus),
		.mismatch_count (mismatch_count),
		.verdicts_due   (verdicts_due)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Offers one byte and waits until the block takes the request. The sender works in
	// bursts: when a burst runs out, a random gap (often none at all) precedes the next.
	// Valid is only lowered when a real gap follows, so it is never dropped and raised
	// again within one time step.
	task automatic push_byte(input logic [BYTE_W-1:0] value, input logic last);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				code_bus.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		code_bus.valid     <= 1'b1;
		code_bus.code_byte <= value;
		code_bus.last_byte <= last;
		do @(posedge clk); while (!code_bus.ready);
	endtask

	task automatic send_region();
		int n;
		int i;
		n = region_bytes.size();
		for (i = 0; i < n; i++)
			push_byte(region_bytes[i], i == n - 1);
		region_bytes.delete();
	endtask

	// Appends one byte to the end of the region being assembled.
	task automatic append_byte(input logic [BYTE_W-1:0] value);
		region_bytes.insert(region_bytes.size(), value);
	endtask

	// A 64-bit value laid down little-endian, as an absolute pointer sits in a data table.
	task automatic add_word(input logic [WORD_W-1:0] w);
		int i;
		for (i = 0; i < WINDOW_BYTES; i++)
			append_byte(w[BYTE_W*i +: BYTE_W]);
	endtask

	// A seven-byte RIP-relative instruction at the current region offset. The displacement
	// is worked out so that the effective address lands on the target, then moved by delta;
	// with a distant target it simply wraps to 32 bits and so misses.
	task automatic add_rip_ref(input logic [BYTE_W-1:0] rex, input logic [BYTE_W-1:0] opcode,
			input logic [BYTE_W-1:0] modrm, input int delta);
		logic [WORD_W-1:0] rip;
		logic [DISP_W-1:0] disp;
		int                i;
		rip  = base_now + WORD_W'(region_bytes.size()) + WORD_W'(7);
		disp = DISP_W'(target_now - rip) + DISP_W'(delta);
		append_byte(rex);
		append_byte(opcode);
		append_byte(modrm);
		for (i = 0; i < DISP_W / BYTE_W; i++)
			append_byte(disp[BYTE_W*i +: BYTE_W]);
	endtask

	// Appends one piece of code. Most pieces are genuine references to the target, some are
	// near misses that break exactly one part of the pattern, and the rest is noise.
	task automatic add_piece();
		logic [BYTE_W-1:0] rex;
		logic [BYTE_W-1:0] opcode;
		logic [BYTE_W-1:0] modrm;
		logic [3:0]        nibble;
		int                delta;
		int                pick;
		pick   = $urandom_range(0, 9);
		rex    = REX_VALUE | BYTE_W'($urandom_range(0, 15));
		opcode = $urandom_range(0, 1) ? OP_LEA : OP_MOV;
		modrm  = (BYTE_W'($urandom) & ~MODRM_MASK) | MODRM_RIP;
		delta  = 0;
		if (pick <= 2) begin
			add_word(target_now);
		end else if (pick <= 5) begin
			add_rip_ref(rex, opcode, modrm, delta);
		end else if (pick == 6) begin
			case ($urandom_range(0, 3))
				0: delta = $urandom_range(0, 1) ? 1 : -1;
				1: begin
					// Any high nibble but that of a REX prefix.
					nibble = 4'($urandom_range(0, 14));
					if (nibble >= REX_VALUE[7:4])
						nibble++;
					rex = {nibble, rex[3:0]};
				end
				2: begin
					opcode = BYTE_W'($urandom);
					if (opcode == OP_LEA || opcode == OP_MOV)
						opcode[0] = ~opcode[0];
				end
				default: begin
					modrm = BYTE_W'($urandom);
					if ((modrm & MODRM_MASK) == MODRM_RIP)
						modrm[6] = ~modrm[6];
				end
			endcase
			add_rip_ref(rex, opcode, modrm, delta);
		end else if (pick == 7) begin
			add_word(target_now ^ (WORD_W'(1) << $urandom_range(0, WORD_W - 1)));
		end else begin
			repeat ($urandom_range(1, 6)) begin
				case ($urandom_range(0, 3))
					0:       append_byte('0);
					1:       append_byte('1);
					default: append_byte(BYTE_W'($urandom));
				endcase
			end
		end
	endtask

	// One region in ten is too short for any position to be judged; the others are long
	// enough for most of their pieces to be judged before the final byte.
	task automatic build_region();
		int goal;
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, WINDOW_BYTES))
				append_byte(BYTE_W'($urandom));
		end else begin
			goal = $urandom_range(WINDOW_BYTES + 1, 64);
			while (region_bytes.size() < goal)
				add_piece();
		end
	endtask

	// Stops sending and waits until every predicted result has come back. The count is
	// sampled on the falling edge, well clear of the checker's update on the rising one.
	task automatic wait_until_drained();
		code_bus.valid <= 1'b0;
		do @(negedge clk); while (verdicts_due != 0);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [WORD_W-1:0] data);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= index;
		cfg_bus.data  <= data;
		do @(posedge clk); while (!cfg_bus.ready);
	endtask

	// Both registers, then a stray write past the end of the list that must change nothing.
	// Only called while the scanner is empty.
	task automatic program_regs(input logic [WORD_W-1:0] target, input logic [WORD_W-1:0] base);
		write_reg(CFG_TARGET, target);
		write_reg(CFG_BASE, base);
		write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, {$urandom, $urandom});
		cfg_bus.valid <= 1'b0;
		target_now = target;
		base_now   = base;
	endtask

	// The receiver changes its manner every so often: always ready, a fixed cadence with
	// one stall in five, a coin toss per cycle, or mostly ready with long stalls now and then.
	initial begin
		stall_mode_t mode;
		int          mode_left;
		int          hold;
		int          beat;
		logic        rdy;
		result_bus.ready <= 1'b0;
		mode      = STALL_NONE;
		mode_left = 0;
		hold      = 0;
		beat      = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (mode_left == 0) begin
				mode      = stall_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 150);
			end
			mode_left--;
			beat++;
			case (mode)
				STALL_NONE:    rdy = 1'b1;
				STALL_CADENCE: rdy = (beat % 5) != 0;
				STALL_COIN:    rdy = $urandom_range(0, 1);
				default: begin
					if (hold > 0) begin
						hold--;
						rdy = 1'b0;
					end else begin
						rdy = 1'b1;
						if ($urandom_range(0, 7) == 0)
							hold = $urandom_range(1, 12);
					end
				end
			endcase
			result_bus.ready <= rdy;
		end
	end

	initial begin
		arst_n             <= 1'b0;
		code_bus.valid     <= 1'b0;
		code_bus.code_byte <= '0;
		code_bus.last_byte <= 1'b0;
		cfg_bus.valid      <= 1'b0;
		cfg_bus.index      <= CFG_TARGET;
		cfg_bus.data       <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. The base sits just below the top of the address space so that
		// judged addresses and the RIP-relative sum both wrap through zero.
		program_regs(WORD_W'(64'h10), 64'hFFFF_FFFF_FFFF_FFFC);
		// A region ending before any position can be judged, with both extreme byte values.
		region_bytes = '{8'h00, 8'hFF, 8'h80};
		send_region();
		// A mov with every REX and ModRM reg bit set, followed straight away by an absolute
		// pointer to the target, then the start of a lea that the end of the region leaves
		// unjudged.
		add_rip_ref(REX_VALUE | 8'h0F, OP_MOV, MODRM_RIP | 8'h38, 0);
		add_word(target_now);
		append_byte(REX_VALUE | 8'h08);
		append_byte(OP_LEA);
		send_region();
		wait_until_drained();

		// Random phases, each under its own settings: the four corners of the address space
		// first, then a fully random pair, then targets within a megabyte of the base where
		// RIP-relative hits are plentiful. Every phase ends with the sender waiting until all
		// results are in, which is also when the registers may be rewritten.
		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: program_regs('0, '0);
				1: program_regs(ALL_ONES, '0);
				2: program_regs('0, ALL_ONES);
				3: program_regs(ALL_ONES, ALL_ONES);
				4: program_regs({$urandom, $urandom}, {$urandom, $urandom});
				default: begin
					offset = int'($urandom_range(0, 1 << 21)) - (1 << 20);
					base_now = {$urandom, $urandom};
					program_regs(base_now + WORD_W'(offset), base_now);
				end
			endcase
			sent = 0;
			while (sent < PHASE_BYTES) begin
				build_region();
				sent += region_bytes.size();
				send_region();
			end
			wait_until_drained();
		end

		// A few more cycles to catch any result the block might still emit unasked.
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && verdicts_due == 0)
			$display("tb_code_reference_scanner_unit passed");
		else
			$display("tb_code_reference_scanner_unit failed");
		$finish;
	end

	// Far beyond the slowest correct run, which needs well under a millisecond.
	initial begin
		#4ms;
		$display("tb_code_reference_scanner_unit failed");
		$finish;
	end

endmodule

/* code_reference_scanner_unit.f */
rtl/crs_pkg.sv
rtl/crs_if.sv
rtl/crs_front.sv
rtl/crs_judge.sv
rtl/code_reference_scanner_unit.sv
tb/crs_scan_checker.sv
tb/tb_code_reference_scanner_unit.sv
